// ----- rtl/wfm_pkg.sv -----
// Shared types and constants for the weighted frame mean block.
// Holds op codes, status codes, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package wfm_pkg;

    // Fixed field widths.
    localparam int OP_W       = 2;
    localparam int FC_W       = 5;
    localparam int NF_W       = 10;
    localparam int POS_W      = 5;
    localparam int IDX_OUT_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    // The element position counter saturates here.
    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    // Input op codes.
    localparam logic [OP_W-1:0] OP_ELEM  = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_WEIGHT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_FRAMES    = 2'd1;

    // Register reset values.
    localparam logic [FC_W-1:0] FC_RESET = 5'd16;
    localparam logic [NF_W-1:0] NF_RESET = 10'd16;

    // Steps of one multiply-add: memory fetch, multiply, accumulate.
    localparam logic [1:0] PH_FETCH = 2'd0;
    localparam logic [1:0] PH_MUL   = 2'd1;
    localparam logic [1:0] PH_ADD   = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_READ,
        S_LOAD,
        S_DIV,
        S_SAT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/weighted_frame_mean.sv -----
// Weighted frame mean: accumulates weighted feature frames and emits per-feature means.
// Uses one shared multiplier and one restoring divider under a small sequencer.
// Depends on wfm_pkg.
//
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in         in_valid/in_ready    op, value, last
// out       out        out_valid/out_ready  mean, feature_index, status, run_end
//
// A feature value, flush with nothing to emit, clear or unused op is handled in the idle state.
// A weight closing a valid frame runs a multiply-add per active feature; the single multiplier
// and the accumulator memory port take the features one at a time: fetch, multiply, accumulate.
// Means over a nonzero weight sum come from the restoring divider, one quotient bit per cycle.
// Reset needs no clearing pass: sums carry valid bits.
// A result waits in the output register; the sequencer holds while that register is full.
`default_nettype none

module weighted_frame_mean
    import wfm_pkg::*;
#(
    parameter int MAX_FEATURES = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration writes.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    // Input items.
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [OP_W-1:0]               op,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          last,
    // Results.
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0]      mean,
    output logic [IDX_OUT_W-1:0]               feature_index,
    output logic [STATUS_W-1:0]                status,
    output logic                               run_end
);

    // Derived widths.
    localparam int VW     = VALUE_WIDTH;
    localparam int PROD_W = 2 * VW + 1;
    localparam int SUM_W  = 2 * VW + 12;
    localparam int WS_W   = VW + 10;
    localparam int IDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNT_W  = $clog2(SUM_W);

    // Saturation limits and the last divider step.
    localparam logic [VW-1:0]    MEAN_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0]    MEAN_LO = {1'b1, {(VW-1){1'b0}}};
    localparam logic [SUM_W-1:0] POS_LIM = {{(SUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [SUM_W-1:0] NEG_LIM = {{(SUM_W-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

    // Sequencer and configuration state.
    state_t                  state_reg, state_next;
    logic [FC_W-1:0]         fc_reg, fc_next;
    logic [NF_W-1:0]         nf_reg, nf_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [NF_W-1:0]         frames_reg, frames_next;
    logic [WS_W-1:0]         ws_reg, ws_next;
    logic [MAX_FEATURES-1:0] sum_vld_reg, sum_vld_next;
    logic [VW-1:0]           weight_reg, weight_next;
    logic [POS_W-1:0]        feat_reg, feat_next;
    logic [1:0]              phase_reg, phase_next;

    // Multiplier and divider datapath.
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]         dvd_reg, dvd_next;
    logic [WS_W-1:0]          rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // Pending result and output register.
    logic [VW-1:0]           res_mean_reg, res_mean_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    res_end_reg, res_end_next;
    logic [IDX_OUT_W-1:0]    res_idx_reg, res_idx_next;
    logic                    run_reg, run_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VW-1:0]           out_mean_reg, out_mean_next;
    logic [IDX_OUT_W-1:0]    out_idx_reg, out_idx_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic                    out_end_reg, out_end_next;

    // Frame value and feature sum memories with registered reads.
    logic [VW-1:0]           fv_mem [MAX_FEATURES];
    logic [SUM_W-1:0]        sum_mem [MAX_FEATURES];
    logic [VW-1:0]           fv_rd_reg;
    logic [SUM_W-1:0]        sum_rd_reg;
    logic                    sum_rd_vld_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        fv_waddr;
    logic                    fv_we;
    logic                    sum_we;
    logic [SUM_W-1:0]        sum_wdata;

    // Helper signals.
    logic                    in_fire;
    logic                    cfg_fire;
    logic                    slot_free;
    logic [POS_W-1:0]        n_active;
    logic [POS_W-1:0]        n_last;
    logic [NF_W-1:0]         frames_inc;
    logic                    mac_done;
    logic [SUM_W-1:0]        sum_eff;
    logic [SUM_W-1:0]        sum_abs;
    logic [WS_W:0]           trial;
    logic                    trial_ge;
    logic [SUM_W-1:0]        q_neg;
    logic                    acc_clear;
    logic                    run_clear;

    // Handshakes.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Active feature count: zero acts as one, large values clamp to the storage depth.
    always_comb
    begin
        if (fc_reg == '0)
        begin
            n_active = POS_W'(1);
        end
        else if (int'(fc_reg) > MAX_FEATURES)
        begin
            n_active = POS_W'(MAX_FEATURES);
        end
        else
        begin
            n_active = fc_reg;
        end
    end

    assign n_last     = n_active - POS_W'(1);
    assign frames_inc = frames_reg + NF_W'(1);
    assign mac_done   = (phase_reg == PH_ADD) && (feat_reg == n_last);
    assign rd_addr    = IDX_W'(feat_reg);
    assign fv_waddr   = IDX_W'(pos_reg);

    // Accumulate and divide arithmetic.
    assign sum_eff   = sum_rd_vld_reg ? sum_rd_reg : '0;
    assign sum_wdata = sum_eff + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum_abs   = sum_eff[SUM_W-1] ? (SUM_W'(0) - sum_eff) : sum_eff;
    assign trial     = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, ws_reg});
    assign q_neg     = SUM_W'(0) - dvd_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        OP_FLUSH:
                        begin
                            if (frames_reg != '0)
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_ELEM:
                        begin
                            if (last)
                            begin
                                state_next = (pos_reg != n_active) ? S_EMIT : S_MAC;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    state_next = (frames_inc == nf_reg) ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = (ws_reg == '0) ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = res_end_reg ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and output values.
    always_comb
    begin
        fc_next         = fc_reg;
        nf_next         = nf_reg;
        pos_next        = pos_reg;
        frames_next     = frames_reg;
        ws_next         = ws_reg;
        sum_vld_next    = sum_vld_reg;
        weight_next     = weight_reg;
        feat_next       = feat_reg;
        phase_next      = phase_reg;
        prod_next       = prod_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        res_mean_next   = res_mean_reg;
        res_status_next = res_status_reg;
        res_end_next    = res_end_reg;
        res_idx_next    = res_idx_reg;
        run_next        = run_reg;
        out_mean_next   = out_mean_reg;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_end_next    = out_end_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        fv_we           = 1'b0;
        sum_we          = 1'b0;
        acc_clear       = 1'b0;
        run_clear       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // Writes to the mapped registers also clear the accumulation.
                if (cfg_fire)
                begin
                    case (cfg_index)
                        REG_FEATURE_COUNT:
                        begin
                            fc_next   = cfg_data[FC_W-1:0];
                            acc_clear = 1'b1;
                        end
                        REG_NUM_FRAMES:
                        begin
                            nf_next   = cfg_data[NF_W-1:0];
                            acc_clear = 1'b1;
                        end
                        default:
                        begin
                            acc_clear = 1'b0;
                        end
                    endcase
                end
                if (in_fire)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            acc_clear = 1'b1;
                        end
                        OP_FLUSH:
                        begin
                            feat_next = '0;
                        end
                        OP_ELEM:
                        begin
                            if (!last)
                            begin
                                // Store the value if it belongs to the frame.
                                fv_we = (pos_reg < n_active);
                                if (pos_reg != POS_MAX)
                                begin
                                    pos_next = pos_reg + POS_W'(1);
                                end
                            end
                            else
                            begin
                                pos_next = '0;
                                if (pos_reg != n_active)
                                begin
                                    // Wrong frame length: report and drop.
                                    res_mean_next   = '0;
                                    res_idx_next    = '0;
                                    res_status_next = STATUS_MISMATCH;
                                    res_end_next    = 1'b1;
                                    run_next        = 1'b0;
                                end
                                else
                                begin
                                    weight_next = value;
                                    feat_next   = '0;
                                    phase_next  = PH_FETCH;
                                end
                            end
                        end
                        default:
                        begin
                            acc_clear = 1'b0;
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                // One feature at a time through the shared multiplier: fetch, multiply, accumulate.
                case (phase_reg)
                    PH_FETCH:
                    begin
                        phase_next = PH_MUL;
                    end
                    PH_MUL:
                    begin
                        prod_next  = $signed(fv_rd_reg) * $signed({1'b0, weight_reg});
                        phase_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        sum_we                = 1'b1;
                        sum_vld_next[rd_addr] = 1'b1;
                        phase_next            = PH_FETCH;
                        if (mac_done)
                        begin
                            ws_next     = ws_reg + WS_W'(weight_reg);
                            frames_next = frames_inc;
                            feat_next   = '0;
                        end
                        else
                        begin
                            feat_next = feat_reg + POS_W'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FETCH;
                    end
                endcase
            end
            S_LOAD:
            begin
                // Set up the division of one feature sum by the weight sum.
                res_idx_next = IDX_OUT_W'(feat_reg);
                res_end_next = (feat_reg == n_last);
                run_next     = 1'b1;
                neg_next     = sum_eff[SUM_W-1];
                dvd_next     = sum_abs;
                rem_next     = '0;
                cnt_next     = '0;
                if (ws_reg == '0)
                begin
                    res_mean_next   = '0;
                    res_status_next = STATUS_ZERO_WEIGHT;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle.
                rem_next = trial_ge ? WS_W'(trial - {1'b0, ws_reg}) : trial[WS_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SAT:
            begin
                // Apply the sign and clamp to the result range.
                res_status_next = STATUS_OK;
                if (!neg_reg)
                begin
                    res_mean_next = (dvd_reg > POS_LIM) ? MEAN_HI : dvd_reg[VW-1:0];
                end
                else
                begin
                    res_mean_next = (dvd_reg > NEG_LIM) ? MEAN_LO : q_neg[VW-1:0];
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_mean_next   = res_mean_reg;
                    out_idx_next    = res_idx_reg;
                    out_status_next = res_status_reg;
                    out_end_next    = res_end_reg;
                    if (res_end_reg)
                    begin
                        run_clear = run_reg;
                    end
                    else
                    begin
                        feat_next = feat_reg + POS_W'(1);
                    end
                end
            end
            default:
            begin
                acc_clear = 1'b0;
            end
        endcase

        // Clearing the accumulation; a finished run keeps the frame in progress.
        if (acc_clear || run_clear)
        begin
            sum_vld_next = '0;
            ws_next      = '0;
            frames_next  = '0;
        end
        if (acc_clear)
        begin
            pos_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fc_reg        <= FC_RESET;
            nf_reg        <= NF_RESET;
            pos_reg       <= '0;
            frames_reg    <= '0;
            ws_reg        <= '0;
            sum_vld_reg   <= '0;
            feat_reg      <= '0;
            phase_reg     <= PH_FETCH;
            cnt_reg       <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            nf_reg        <= nf_next;
            pos_reg       <= pos_next;
            frames_reg    <= frames_next;
            ws_reg        <= ws_next;
            sum_vld_reg   <= sum_vld_next;
            feat_reg      <= feat_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        weight_reg     <= weight_next;
        prod_reg       <= prod_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        neg_reg        <= neg_next;
        res_mean_reg   <= res_mean_next;
        res_status_reg <= res_status_next;
        res_end_reg    <= res_end_next;
        res_idx_reg    <= res_idx_next;
        out_mean_reg   <= out_mean_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_end_reg    <= out_end_next;
    end

    // Frame value memory.
    always_ff @(posedge clk)
    begin
        if (fv_we)
        begin
            fv_mem[fv_waddr] <= value;
        end
        fv_rd_reg <= fv_mem[rd_addr];
    end

    // Feature sum memory; the valid bit is read alongside the data.
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[rd_addr] <= sum_wdata;
        end
        sum_rd_reg     <= sum_mem[rd_addr];
        sum_rd_vld_reg <= sum_vld_reg[rd_addr];
    end

    // Result ports.
    assign out_valid     = out_valid_reg;
    assign mean          = out_mean_reg;
    assign feature_index = out_idx_reg;
    assign status        = out_status_reg;
    assign run_end       = out_end_reg;

endmodule

`default_nettype wire

// ----- bench/wfm_checker.sv -----
// Result checker for the weighted frame mean block: watches all three channels,
// predicts the means of every accepted transaction and compares them in order.
// Depends on wfm_pkg.
`default_nettype none

module wfm_checker
    import wfm_pkg::*;
#(
    parameter int MAX_FEATURES = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [OP_W-1:0]               op,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          last,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] mean,
    input  wire logic [IDX_OUT_W-1:0]          feature_index,
    input  wire logic [STATUS_W-1:0]           status,
    input  wire logic                          run_end,
    output int unsigned                        means_waiting,
    output int unsigned                        error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Accumulator widths: the sums hold a full frame count of worst-case products.
    localparam int SUM_W  = 2 * VALUE_WIDTH + NF_W + 2;
    localparam int WSUM_W = VALUE_WIDTH + NF_W;
    localparam longint MEAN_HI = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint MEAN_LO = -MEAN_HI - 1;
    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] mean;
        logic [IDX_OUT_W-1:0]          feature_index;
        logic [STATUS_W-1:0]           status;
        logic                          run_end;
    } mean_result_t;

    // Means predicted but not yet seen on the output channel, oldest first.
    mean_result_t expected_means[$];

    // Shadow of the block's registers and accumulation state.
    logic [FC_W-1:0]               feature_count_q;
    logic [NF_W-1:0]               frame_target_q;
    logic signed [VALUE_WIDTH-1:0] frame_buf [MAX_FEATURES];
    logic signed [SUM_W-1:0]       feature_acc [MAX_FEATURES];
    logic [WSUM_W-1:0]             weight_acc;
    logic [NF_W-1:0]               frames_seen;
    logic [POS_W-1:0]              elem_pos;

    // Feature count as the block applies it: zero acts as one, large values saturate.
    function automatic int unsigned active_count();
        int unsigned n;
        n = feature_count_q;
        if (n < 1)
            n = 1;
        if (n > MAX_FEATURES)
            n = MAX_FEATURES;
        return n;
    endfunction

    function automatic void clear_sums();
        foreach (feature_acc[i])
            feature_acc[i] = '0;
        weight_acc  = '0;
        frames_seen = '0;
        elem_pos    = '0;
    endfunction

    // Queue one mean per active feature, then start a fresh accumulation.
    function automatic void queue_means();
        int unsigned n;
        longint q;
        mean_result_t r;
        n = active_count();
        for (int i = 0; i < n; i++) begin
            q = 0;
            r.status = STATUS_ZERO_WEIGHT;
            if (weight_acc != 0) begin
                q = longint'(feature_acc[i]) / longint'(weight_acc);
                if (q > MEAN_HI)
                    q = MEAN_HI;
                if (q < MEAN_LO)
                    q = MEAN_LO;
                r.status = STATUS_OK;
            end
            r.mean          = VALUE_WIDTH'(q);
            r.feature_index = IDX_OUT_W'(i);
            r.run_end       = (i == n - 1);
            expected_means.push_back(r);
        end
        foreach (feature_acc[i])
            feature_acc[i] = '0;
        weight_acc  = '0;
        frames_seen = '0;
    endfunction

    // A write to either register also drops everything accumulated so far.
    function automatic void apply_register(input logic [CFG_ADDR_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_FEATURE_COUNT) begin
            feature_count_q = data[FC_W-1:0];
            clear_sums();
        end else if (idx == REG_NUM_FRAMES) begin
            frame_target_q = data[NF_W-1:0];
            clear_sums();
        end
    endfunction

    // Advance the prediction by one accepted input transaction.
    function automatic void take_item(input logic [OP_W-1:0] op_i,
                                      input logic signed [VALUE_WIDTH-1:0] v,
                                      input logic last_i);
        int unsigned n;
        mean_result_t r;
        n = active_count();
        if (op_i == OP_CLEAR) begin
            clear_sums();
        end else if (op_i == OP_FLUSH) begin
            if (frames_seen != 0)
                queue_means();
        end else if (op_i == OP_ELEM) begin
            if (!last_i) begin
                // Values past the frame length are not stored; the position saturates.
                if (elem_pos < n)
                    frame_buf[elem_pos] = v;
                if (elem_pos != POS_MAX)
                    elem_pos = elem_pos + 1'b1;
            end else if (elem_pos != n) begin
                // Wrong frame length: drop the frame and report it once.
                elem_pos = '0;
                r.mean          = '0;
                r.feature_index = '0;
                r.status        = STATUS_MISMATCH;
                r.run_end       = 1'b1;
                expected_means.push_back(r);
            end else begin
                elem_pos = '0;
                for (int i = 0; i < n; i++)
                    feature_acc[i] = feature_acc[i]
                        + SUM_W'(longint'(frame_buf[i]) * longint'($unsigned(v)));
                weight_acc  = weight_acc + $unsigned(v);
                frames_seen = frames_seen + 1'b1;
                if (frames_seen == frame_target_q)
                    queue_means();
            end
        end
    endfunction

    // Results are checked before new transactions are predicted, since a result
    // can never come from an input accepted on the same edge.
    always @(posedge clk or negedge rst_n) begin : track
        mean_result_t got;
        mean_result_t want;
        if (!rst_n) begin
            feature_count_q = FC_RESET;
            frame_target_q  = NF_RESET;
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            clear_sums();
            expected_means.delete();
            error_count = 0;
        end else begin
            if (out_valid && out_ready) begin
                got = '{mean, feature_index, status, run_end};
                if (expected_means.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("%0t: unexpected result: expected none, got mean %0d index %0d status %0d run_end %0d",
                                 $time, got.mean, got.feature_index, got.status, got.run_end);
                end else begin
                    want = expected_means.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= REPORT_CAP)
                            $display("%0t: expected mean %0d index %0d status %0d run_end %0d, got mean %0d index %0d status %0d run_end %0d",
                                     $time, want.mean, want.feature_index, want.status,
                                     want.run_end, got.mean, got.feature_index, got.status,
                                     got.run_end);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                take_item(op, value, last);
        end
        means_waiting = expected_means.size();
    end

endmodule

`default_nettype wire

// ----- bench/weighted_frame_mean_tb.sv -----
// Top-level testbench for the weighted frame mean block: drives directed and random
// frames under several register settings and reports the verdict.
// Depends on wfm_pkg, weighted_frame_mean and wfm_checker.
`default_nettype none

module weighted_frame_mean_tb
    import wfm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FEAT        = 16;
    localparam int VALUE_W         = 16;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 30;
    localparam int TARGET_ITEMS    = 450;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = (TARGET_ITEMS - 26) / PHASES;
    // After the last expected mean, a correct block stays busy at most for one weight's multiply-adds.
    localparam int QUIET_CYCLES    = 3 * MAX_FEAT + 16;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam logic [OP_W-1:0]       OP_UNUSED  = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_ADDR_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [OP_W-1:0]             op;
    logic signed [VALUE_W-1:0]   value;
    logic                        last;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [VALUE_W-1:0]   mean;
    logic [IDX_OUT_W-1:0]        feature_index;
    logic [STATUS_W-1:0]         status;
    logic                        run_end;

    int unsigned means_waiting;
    int unsigned mismatch_count;
    int unsigned items_sent = 0;
    int unsigned stall_cycles = 0;
    bit          steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    weighted_frame_mean #(
        .MAX_FEATURES(MAX_FEAT),
        .VALUE_WIDTH (VALUE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean         (mean),
        .feature_index(feature_index),
        .status       (status),
        .run_end      (run_end)
    );

    wfm_checker #(
        .MAX_FEATURES(MAX_FEAT),
        .VALUE_WIDTH (VALUE_W)
    ) mean_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean         (mean),
        .feature_index(feature_index),
        .status       (status),
        .run_end      (run_end),
        .means_waiting(means_waiting),
        .error_count  (mismatch_count)
    );

    // The result side stalls at random, except during the steady phase.
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // End the run if no transaction moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Feature values lean toward the extremes of the signed range.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            3: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Weights cover zero, the largest weight and small weights.
    function automatic logic signed [VALUE_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(512, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned active_of(input int unsigned fc);
        if (fc < 1)
            return 1;
        if (fc > MAX_FEAT)
            return MAX_FEAT;
        return fc;
    endfunction

    // Start at the next falling edge, idle at random, then hold the transaction
    // until it is accepted. Returns right after the accepting edge.
    task automatic send_item(input logic [OP_W-1:0] op_i,
                             input logic signed [VALUE_W-1:0] value_i,
                             input logic last_i);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_i;
        value    <= value_i;
        last     <= last_i;
        do @(posedge clk); while (!in_ready);
        if (op_i != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_values(input int unsigned count);
        repeat (count) send_item(OP_ELEM, pick_value(), 1'b0);
    endtask

    task automatic send_weight();
        send_item(OP_ELEM, pick_weight(), 1'b1);
    endtask

    task automatic send_control(input logic [OP_W-1:0] op_i);
        send_item(op_i, 16'($urandom), 1'($urandom));
    endtask

    // Drop the input valid, wait for every expected mean, then let the block settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (means_waiting != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned phase_fc [PHASES];
        int unsigned phase_nf [PHASES];
        int unsigned n;
        int unsigned len;
        int unsigned k;
        int unsigned roll;
        int unsigned phase_end;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FEATURE_COUNT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        op        = OP_ELEM;
        value     = '0;
        last      = 1'b0;

        // Settings per phase, extremes first; the last phase is drawn at random.
        phase_fc = '{1, 16, 0, 31, 3, 7, 5, 0};
        phase_nf = '{1, 3, 1023, 0, 2, 1, 4, 0};
        phase_fc[PHASES-1] = $urandom_range(MAX_FEAT, 1);
        phase_nf[PHASES-1] = $urandom_range(8, 1);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with two features per frame and two frames per run.
        write_register(REG_FEATURE_COUNT, {5'($urandom), 5'd2});
        write_register(REG_NUM_FRAMES, 10'd2);

        // Extreme values under the largest weight, then a zero-weight frame ends the run.
        send_item(OP_ELEM, 16'h7FFF, 1'b0);
        send_item(OP_ELEM, 16'h8000, 1'b0);
        send_item(OP_ELEM, 16'hFFFF, 1'b1);
        send_item(OP_ELEM, 16'hFFFF, 1'b0);
        send_item(OP_ELEM, 16'h0001, 1'b0);
        send_item(OP_ELEM, 16'h0000, 1'b1);

        // A single zero-weight frame flushed gives the zero-weight status.
        send_item(OP_ELEM, 16'h8000, 1'b0);
        send_item(OP_ELEM, 16'h0100, 1'b0);
        send_item(OP_ELEM, 16'h0000, 1'b1);
        send_control(OP_FLUSH);

        // Flush with nothing completed gives no result.
        send_control(OP_FLUSH);

        // Frames too short and too long are dropped.
        send_item(OP_ELEM, 16'h0005, 1'b0);
        send_item(OP_ELEM, 16'h0064, 1'b1);
        send_item(OP_ELEM, 16'h0001, 1'b0);
        send_item(OP_ELEM, 16'h0002, 1'b0);
        send_item(OP_ELEM, 16'h0003, 1'b0);
        send_item(OP_ELEM, 16'h0064, 1'b1);

        // A flush in the middle of a frame keeps the partial frame.
        send_item(OP_ELEM, 16'h012C, 1'b0);
        send_item(OP_ELEM, 16'hFED4, 1'b0);
        send_item(OP_ELEM, 16'h0100, 1'b1);
        send_item(OP_ELEM, 16'h004D, 1'b0);
        send_control(OP_FLUSH);
        send_item(OP_ELEM, 16'h0058, 1'b0);
        send_item(OP_ELEM, 16'h0200, 1'b1);

        // Clear drops the completed frame; the unused op is ignored.
        send_control(OP_CLEAR);
        send_control(OP_UNUSED);
        send_control(OP_FLUSH);

        // A write to an unmapped register index changes nothing.
        write_register(REG_UNUSED, 10'($urandom));

        // Random part: mostly well-formed frames, with flushes, clears and broken frames.
        for (int p = 0; p < PHASES; p++)
        begin
            n = active_of(phase_fc[p]);
            write_register(REG_FEATURE_COUNT, {5'($urandom), 5'(phase_fc[p])});
            write_register(REG_NUM_FRAMES, 10'(phase_nf[p]));
            steady    = (p == 2);
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
            begin
                roll = $urandom_range(99);
                if (roll < 74)
                begin
                    send_values(n);
                    send_weight();
                end
                else if (roll < 80)
                begin
                    // For n > 1, half the flushes land inside a frame that completes afterward.
                    if (n > 1 && $urandom_range(1))
                    begin
                        k = $urandom_range(n - 1, 1);
                        send_values(k);
                        send_control(OP_FLUSH);
                        send_values(n - k);
                        send_weight();
                    end
                    else
                    begin
                        send_control(OP_FLUSH);
                    end
                end
                else if (roll < 83)
                begin
                    send_control(OP_CLEAR);
                end
                else if (roll < 85)
                begin
                    send_control(OP_UNUSED);
                end
                else if (roll < 97)
                begin
                    len = $urandom_range(n + 2, 0);
                    if (len == n)
                        len = n + 1;
                    send_values(len);
                    send_weight();
                end
                else
                begin
                    // Long enough to saturate the element position.
                    send_values(32 + $urandom_range(3));
                    send_weight();
                end
            end
        end

        steady = 1'b0;
        wait_idle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/wfm_pkg.sv
rtl/weighted_frame_mean.sv
bench/wfm_checker.sv
bench/weighted_frame_mean_tb.sv
